// ----- src/tsc_pkg.sv -----
// ----------------------------------------------------------------------------
// tsc_pkg
// shared types, constants and calendar helpers for the timestep stamper
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int STEP_W  = 14;
    localparam int REM_W   = 15;
    localparam int IDX_W   = 2;
    localparam int CFG_W   = 14;

    localparam logic [IDX_W-1:0] REG_START_YEAR  = 2'd0;
    localparam logic [IDX_W-1:0] REG_START_MONTH = 2'd1;
    localparam logic [IDX_W-1:0] REG_START_DAY   = 2'd2;
    localparam logic [IDX_W-1:0] REG_HOURS_STEP  = 2'd3;

    localparam logic [YEAR_W-1:0]  RST_YEAR  = 12'd2000;
    localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;
    localparam logic [STEP_W-1:0]  RST_STEP  = 14'd24;

    localparam logic [STEP_W-1:0]  YEARLY_HOURS  = 14'd8760;
    localparam logic [STEP_W-1:0]  MONTHLY_HOURS = 14'd744;
    localparam logic [REM_W-1:0]   DAY_HOURS     = 15'd24;
    localparam logic [MONTH_W-1:0] LAST_MONTH    = 4'd12;
    localparam logic [5:0]         MIN_MONTH_LEN = 6'd28;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_t;

    typedef enum logic [1:0] {
        CAL_HOLD,
        CAL_DAY,
        CAL_MONTH,
        CAL_YEAR
    } cal_op_t;

    // multiples of 100 and 400 in the 12-bit year range
    function automatic logic is_leap(input logic [YEAR_W-1:0] year);
        logic cent;
        logic quad;
        cent = 1'b0;
        quad = 1'b0;
        for (int k = 0; k <= 40; k++)
        begin
            if (year == YEAR_W'(k * 100))
                cent = 1'b1;
        end
        for (int k = 0; k <= 10; k++)
        begin
            if (year == YEAR_W'(k * 400))
                quad = 1'b1;
        end
        return (year[1:0] == 2'b00) && !(cent && !quad);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- src/tsc_cal_unit.sv -----
// ----------------------------------------------------------------------------
// tsc_cal_unit
// shared calendar carry unit: one day, month or year increment per use
// ----------------------------------------------------------------------------
module tsc_cal_unit
    import tsc_pkg::*;
(
    input  date_t   cur,
    input  cal_op_t op,
    output date_t   nxt
);

    logic [5:0]         day_inc;
    logic [DAY_W-1:0]   mlen;
    logic [MONTH_W-1:0] month_inc;
    logic               month_wrap;
    logic [YEAR_W-1:0]  year_inc;

    always_comb
    begin
        day_inc    = {1'b0, cur.day} + 6'd1;
        mlen       = month_len(cur.month, is_leap(cur.year));
        month_inc  = cur.month + 4'd1;
        month_wrap = (month_inc > LAST_MONTH) || (month_inc == 4'd0);
        year_inc   = cur.year + 12'd1;
        nxt        = cur;
        case (op)
            CAL_YEAR:
            begin
                nxt.year = year_inc;
            end
            CAL_MONTH:
            begin
                if (month_wrap)
                begin
                    nxt.month = 4'd1;
                    nxt.year  = year_inc;
                end
                else
                begin
                    nxt.month = month_inc;
                end
            end
            CAL_DAY:
            begin
                if ((day_inc > MIN_MONTH_LEN) && (day_inc > {1'b0, mlen}))
                begin
                    nxt.day = 5'd1;
                    if (month_wrap)
                    begin
                        nxt.month = 4'd1;
                        nxt.year  = year_inc;
                    end
                    else
                    begin
                        nxt.month = month_inc;
                    end
                end
                else
                begin
                    nxt.day = day_inc[DAY_W-1:0];
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// ----- src/timestep_calendar_stamper.sv -----
// ----------------------------------------------------------------------------
// timestep_calendar_stamper
// emits one calendar stamp per request beat and advances the date
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_stall carries first_step; output channel
//   out_valid/out_stall carries stamp_year/month/day/hour, one beat per input.
//   cfg_we/cfg_index/cfg_data write start_year (0), start_month (1),
//   start_day (2) and hours_per_step (3); write only while idle.
//   the stamp is registered and appears on the output in the cycle after the input beat.
//   the date then advances through a single shared day/month/year carry
//   unit: yearly (8760) and monthly (744) steps move the year or the month on
//   once, any other step advances floor((hour + hours_per_step) / 24) days,
//   one day per cycle.
//   in_stall is high while advancing and while a stamp waits on the output;
//   the next beat is taken once both are done.
//   a stalled output beat holds its value until taken.
//   reset loads 2000-01-01 hour 0 and a 24 hour step.
// ----------------------------------------------------------------------------
module timestep_calendar_stamper
    import tsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               first_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [YEAR_W-1:0]  stamp_year,
    output logic [MONTH_W-1:0] stamp_month,
    output logic [DAY_W-1:0]   stamp_day,
    output logic [HOUR_W-1:0]  stamp_hour
);

    typedef enum logic {
        ST_IDLE,
        ST_ADV
    } state_t;

    state_t             state_reg;
    logic [YEAR_W-1:0]  start_year_reg;
    logic [MONTH_W-1:0] start_month_reg;
    logic [DAY_W-1:0]   start_day_reg;
    logic [STEP_W-1:0]  step_reg;
    date_t              date_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [REM_W-1:0]   rem_reg;
    logic               out_valid_reg;
    logic [YEAR_W-1:0]  stamp_year_reg;
    logic [MONTH_W-1:0] stamp_month_reg;
    logic [DAY_W-1:0]   stamp_day_reg;
    logic [HOUR_W-1:0]  stamp_hour_reg;

    logic               in_take;
    logic               out_take;
    logic               yearly;
    logic               monthly;
    date_t              eff_date;
    logic [HOUR_W-1:0]  eff_hour;
    cal_op_t            cal_op;
    date_t              cal_next;

    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign yearly   = (step_reg == YEARLY_HOURS);
    assign monthly  = (step_reg == MONTHLY_HOURS);

    assign out_valid   = out_valid_reg;
    assign stamp_year  = stamp_year_reg;
    assign stamp_month = stamp_month_reg;
    assign stamp_day   = stamp_day_reg;
    assign stamp_hour  = stamp_hour_reg;

    always_comb
    begin
        if (first_step)
        begin
            eff_date.year  = start_year_reg;
            eff_date.month = start_month_reg;
            eff_date.day   = start_day_reg;
            eff_hour       = '0;
        end
        else
        begin
            eff_date = date_reg;
            eff_hour = hour_reg;
        end
    end

    always_comb
    begin
        cal_op = CAL_HOLD;
        if (state_reg == ST_ADV)
        begin
            if (yearly)
                cal_op = CAL_YEAR;
            else if (monthly)
                cal_op = CAL_MONTH;
            else if (rem_reg >= DAY_HOURS)
                cal_op = CAL_DAY;
        end
    end

    tsc_cal_unit u_cal (
        .cur (date_reg),
        .op  (cal_op),
        .nxt (cal_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_year_reg  <= RST_YEAR;
            start_month_reg <= RST_MONTH;
            start_day_reg   <= RST_DAY;
            step_reg        <= RST_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_YEAR:  start_year_reg  <= cfg_data[YEAR_W-1:0];
                REG_START_MONTH: start_month_reg <= cfg_data[MONTH_W-1:0];
                REG_START_DAY:   start_day_reg   <= cfg_data[DAY_W-1:0];
                REG_HOURS_STEP:  step_reg        <= cfg_data[STEP_W-1:0];
                default:         step_reg        <= step_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            date_reg.year   <= RST_YEAR;
            date_reg.month  <= RST_MONTH;
            date_reg.day    <= RST_DAY;
            hour_reg        <= '0;
            rem_reg         <= '0;
            out_valid_reg   <= 1'b0;
            stamp_year_reg  <= '0;
            stamp_month_reg <= '0;
            stamp_day_reg   <= '0;
            stamp_hour_reg  <= '0;
        end
        else
        begin
            if (out_take)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        date_reg       <= eff_date;
                        hour_reg       <= eff_hour;
                        rem_reg        <= REM_W'(eff_hour) + REM_W'(step_reg);
                        out_valid_reg  <= 1'b1;
                        state_reg      <= ST_ADV;
                        stamp_year_reg <= eff_date.year;
                        if (yearly)
                        begin
                            stamp_month_reg <= 4'd1;
                            stamp_day_reg   <= 5'd1;
                            stamp_hour_reg  <= '0;
                        end
                        else if (monthly)
                        begin
                            stamp_month_reg <= eff_date.month;
                            stamp_day_reg   <= 5'd1;
                            stamp_hour_reg  <= '0;
                        end
                        else
                        begin
                            stamp_month_reg <= eff_date.month;
                            stamp_day_reg   <= eff_date.day;
                            stamp_hour_reg  <= eff_hour;
                        end
                    end
                end
                ST_ADV:
                begin
                    date_reg <= cal_next;
                    if (yearly || monthly)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (rem_reg >= DAY_HOURS)
                    begin
                        rem_reg <= rem_reg - DAY_HOURS;
                    end
                    else
                    begin
                        hour_reg  <= rem_reg[HOUR_W-1:0];
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/tsc_checker.sv -----
// ----------------------------------------------------------------------------
// tsc_checker
// port level checks for the timestep stamper, bound to the top level
// ----------------------------------------------------------------------------
module tsc_checker
    import tsc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [YEAR_W-1:0]  stamp_year,
    input logic [MONTH_W-1:0] stamp_month,
    input logic [DAY_W-1:0]   stamp_day,
    input logic [HOUR_W-1:0]  stamp_hour
);

    logic in_beat;

    assign in_beat = in_valid && !in_stall;

    a_beat_makes_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> out_valid)
        else $error("input beat not followed by a stamp");

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> in_stall)
        else $error("input taken again before the stamp was delivered");

    a_hour_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stamp_hour < 5'd24))
        else $error("stamp hour out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(stamp_year)
            && $stable(stamp_month) && $stable(stamp_day) && $stable(stamp_hour)))
        else $error("stalled output beat changed");

endmodule

bind timestep_calendar_stamper tsc_checker u_tsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stamp_year  (stamp_year),
    .stamp_month (stamp_month),
    .stamp_day   (stamp_day),
    .stamp_hour  (stamp_hour)
);

// ----- tb/sv/stamp_checker.sv -----
// ----------------------------------------------------------------------------
// stamp_checker
// tracks register writes and request beats, keeps its own calendar state,
// predicts the stamp for every request and compares it with the stamp beats
// ----------------------------------------------------------------------------
module stamp_checker
    import tsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               first_step,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [YEAR_W-1:0]  stamp_year,
    input  logic [MONTH_W-1:0] stamp_month,
    input  logic [DAY_W-1:0]   stamp_day,
    input  logic [HOUR_W-1:0]  stamp_hour,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
    } stamp_t;

    logic [YEAR_W-1:0]  start_year_q;
    logic [MONTH_W-1:0] start_month_q;
    logic [DAY_W-1:0]   start_day_q;
    logic [STEP_W-1:0]  step_q;

    logic [YEAR_W-1:0]  cur_year;
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;
    logic [HOUR_W-1:0]  cur_hour;

    stamp_t expected_stamps[$];
    int     bad = 0;

    function automatic int days_in(input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo);
        int n;
        int y;
        y = yr;
        case (mo)
            4'd2:                    n = ((y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0)))
                                         ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 30;
            default:                 n = 31;
        endcase
        return n;
    endfunction

    function automatic void roll_month();
        cur_month = cur_month + 1'b1;
        if (cur_month > LAST_MONTH || cur_month == '0)
        begin
            cur_month = MONTH_W'(1);
            cur_year  = cur_year + 1'b1;
        end
    endfunction

    function automatic void roll_day();
        int d;
        d = int'(cur_day) + 1;
        if (d > 28 && d > days_in(cur_year, cur_month))
        begin
            d = 1;
            roll_month();
        end
        cur_day = DAY_W'(d);
    endfunction

    function automatic void advance(input int hours);
        int total;
        int days;
        total    = int'(cur_hour) + hours;
        days     = total / 24;
        cur_hour = HOUR_W'(total % 24);
        repeat (days) roll_day();
    endfunction

    function automatic stamp_t next_stamp(input logic reload);
        stamp_t s;
        if (reload)
        begin
            cur_year  = start_year_q;
            cur_month = start_month_q;
            cur_day   = start_day_q;
            cur_hour  = '0;
        end
        s.year = cur_year;
        if (step_q == YEARLY_HOURS)
        begin
            s.month  = MONTH_W'(1);
            s.day    = DAY_W'(1);
            s.hour   = '0;
            cur_year = cur_year + 1'b1;
        end
        else if (step_q == MONTHLY_HOURS)
        begin
            s.month = cur_month;
            s.day   = DAY_W'(1);
            s.hour  = '0;
            roll_month();
        end
        else
        begin
            s.month = cur_month;
            s.day   = cur_day;
            s.hour  = cur_hour;
            advance(int'(step_q));
        end
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        stamp_t want;
        stamp_t got;
        if (!rst_n)
        begin
            start_year_q  = RST_YEAR;
            start_month_q = RST_MONTH;
            start_day_q   = RST_DAY;
            step_q        = RST_STEP;
            cur_year      = RST_YEAR;
            cur_month     = RST_MONTH;
            cur_day       = RST_DAY;
            cur_hour      = '0;
            expected_stamps.delete();
            outstanding  <= 0;
            mismatches   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {stamp_year, stamp_month, stamp_day, stamp_hour};
                if (expected_stamps.size() == 0)
                begin
                    bad++;
                    if (bad <= REPORT_MAX)
                        $display("unexpected stamp beat %0d-%0d-%0d h%0d at %0t",
                                 got.year, got.month, got.day, got.hour, $realtime);
                end
                else
                begin
                    want = expected_stamps.pop_front();
                    if (got !== want)
                    begin
                        bad++;
                        if (bad <= REPORT_MAX)
                            $display("stamp mismatch at %0t: expected %0d-%0d-%0d h%0d, got %0d-%0d-%0d h%0d",
                                     $realtime, want.year, want.month, want.day, want.hour,
                                     got.year, got.month, got.day, got.hour);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_START_YEAR:  start_year_q  = cfg_data[YEAR_W-1:0];
                    REG_START_MONTH: start_month_q = cfg_data[MONTH_W-1:0];
                    REG_START_DAY:   start_day_q   = cfg_data[DAY_W-1:0];
                    REG_HOURS_STEP:  step_q        = cfg_data[STEP_W-1:0];
                    default:         ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_stamps.push_back(next_stamp(first_step));
            outstanding <= expected_stamps.size();
            mismatches  <= bad;
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives the timestep stamper through directed calendar corners and random
// start dates and step sizes with random idling on both channels; the
// stamp_checker beside the block predicts and compares every stamp beat
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsc_pkg::*;

    localparam int SETTLE_CYCLES   = 720;
    localparam int STUCK_LIMIT     = 5000;
    localparam int SQUEEZE_CYCLES  = 400;
    localparam int RANDOM_PHASES   = 30;
    localparam int ITEMS_PER_PHASE = 60;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    logic [IDX_W-1:0]   cfg_index   = '0;
    logic [CFG_W-1:0]   cfg_data    = '0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic               first_step  = 1'b0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [YEAR_W-1:0]  stamp_year;
    logic [MONTH_W-1:0] stamp_month;
    logic [DAY_W-1:0]   stamp_day;
    logic [HOUR_W-1:0]  stamp_hour;

    int   mismatches;
    int   outstanding;
    bit   calm        = 1'b0;
    bit   squeeze_req = 1'b0;

    always #1 clk = ~clk;

    timestep_calendar_stamper u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .first_step  (first_step),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .stamp_year  (stamp_year),
        .stamp_month (stamp_month),
        .stamp_day   (stamp_day),
        .stamp_hour  (stamp_hour)
    );

    stamp_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .first_step  (first_step),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .stamp_year  (stamp_year),
        .stamp_month (stamp_month),
        .stamp_day   (stamp_day),
        .stamp_hour  (stamp_hour),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // all stamps taken, then room for the trailing date advance
    task automatic wait_drained();
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_calendar(input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo,
                                 input logic [DAY_W-1:0] dy, input logic [STEP_W-1:0] step);
        wait_drained();
        write_reg(REG_START_YEAR,  {2'($urandom), yr});
        write_reg(REG_START_MONTH, {10'($urandom), mo});
        write_reg(REG_START_DAY,   {9'($urandom), dy});
        write_reg(REG_HOURS_STEP,  step);
    endtask

    task automatic set_step(input logic [STEP_W-1:0] step);
        wait_drained();
        write_reg(REG_HOURS_STEP, step);
    endtask

    task automatic send_beat(input logic fs);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        first_step <= fs;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_run(input int n, input logic reload);
        for (int i = 0; i < n; i++)
            send_beat((i == 0) ? reload : ($urandom_range(0, 19) == 0));
        in_valid <= 1'b0;
    endtask

    // output side
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                hold = SQUEEZE_CYCLES;
            end
            else
                hold = calm ? 0 : $urandom_range(0, 5);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // watchdog
    initial
    begin
        int stuck;
        stuck = 0;
        @(posedge rst_n);
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                stuck = 0;
            else
                stuck++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [YEAR_W-1:0]  yr;
        logic [MONTH_W-1:0] mo;
        logic [DAY_W-1:0]   dy;
        logic [STEP_W-1:0]  step;
        int                 r;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset calendar, no register written yet
        send_run(2, 1'b0);
        // yearly with year wrap, then switch to monthly on the same state
        load_calendar(12'd4094, 4'd1, 5'd1, YEARLY_HOURS);
        send_run(3, 1'b1);
        set_step(MONTHLY_HOURS);
        send_run(2, 1'b0);
        load_calendar(12'd2023, 4'd11, 5'd15, MONTHLY_HOURS);
        send_run(3, 1'b1);
        // february in leap, century and year zero cases
        load_calendar(12'd2000, 4'd2, 5'd28, 14'd24);
        send_run(2, 1'b1);
        load_calendar(12'd1900, 4'd2, 5'd28, 14'd24);
        send_run(2, 1'b1);
        load_calendar(12'd0, 4'd2, 5'd28, 14'd23);
        send_run(3, 1'b1);
        // year wrap through day carry
        load_calendar(12'd4095, 4'd12, 5'd31, 14'd24);
        send_run(2, 1'b1);
        // bad month, bad days, zero step, largest step
        load_calendar(12'd2001, 4'd13, 5'd31, 14'd24);
        send_run(2, 1'b1);
        load_calendar(12'd2001, 4'd0, 5'd0, 14'd0);
        send_run(2, 1'b1);
        load_calendar(12'd2001, 4'd2, 5'd30, 14'd24);
        send_run(2, 1'b1);
        load_calendar(12'd3000, 4'd15, 5'd31, 14'd16383);
        send_run(2, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            calm = (p % 5 == 2);
            if (p == 3)
                squeeze_req = 1'b1;
            r = $urandom_range(0, 15);
            if (r < 2)
                step = YEARLY_HOURS;
            else if (r < 4)
                step = MONTHLY_HOURS;
            else if (r == 4)
                step = STEP_W'($urandom_range(0, 23));
            else if (r == 5)
                step = STEP_W'($urandom);
            else if (r < 8)
                step = STEP_W'($urandom_range(24, 9000));
            else
                step = STEP_W'($urandom_range(24, 240));
            if ($urandom_range(0, 3) == 0)
            begin
                set_step(step);
                send_run(ITEMS_PER_PHASE, 1'($urandom_range(0, 1)));
            end
            else
            begin
                r = $urandom_range(0, 7);
                if (r == 0)
                    yr = YEAR_W'($urandom_range(4090, 4095));
                else if (r == 1)
                    yr = YEAR_W'($urandom_range(0, 5));
                else if (r == 2)
                    yr = YEAR_W'($urandom);
                else
                    yr = YEAR_W'($urandom_range(1900, 3000));
                if ($urandom_range(0, 9) == 0)
                    mo = MONTH_W'($urandom_range(0, 15));
                else
                    mo = MONTH_W'($urandom_range(1, 12));
                if ($urandom_range(0, 7) == 0)
                    dy = DAY_W'($urandom_range(0, 31));
                else
                    dy = DAY_W'($urandom_range(1, 28));
                load_calendar(yr, mo, dy, step);
                send_run(ITEMS_PER_PHASE, 1'b1);
            end
        end

        calm = 1'b0;
        wait_drained();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- sim.f -----
src/tsc_pkg.sv
src/tsc_cal_unit.sv
src/timestep_calendar_stamper.sv
src/tsc_checker.sv
tb/sv/stamp_checker.sv
tb/sv/tb_top.sv
